// ----- hw/rtl/rigid_body_impulse_resolver_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Rigid body impulse resolver: assertion macros
// Checks compile to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef RIGID_BODY_IMPULSE_RESOLVER_UNIT_DEFINES_SVH
`define RIGID_BODY_IMPULSE_RESOLVER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define RBIR_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("rbir: implication check failed");
// Next-cycle implication.
`define RBIR_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("rbir: next-cycle check failed");
`else
`define RBIR_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons)
`define RBIR_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons)
`endif

`endif

// ----- hw/rtl/rbir_pkg.sv -----
// ----------------------------------------------------------------------------
// rbir_pkg
// Types, constants and fixed-point helpers for the impulse resolver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rbir_pkg;

  localparam int unsigned WORD_W      = 32;
  localparam int unsigned WIDE_W      = 64;
  localparam int unsigned NUM_W       = 48;
  localparam int unsigned FACTOR_W    = 20;
  localparam int unsigned DIV_LANES   = 1;
  localparam int unsigned DIV_NUM_W   = 48;
  localparam int unsigned DIV_DEN_W   = 32;
  localparam int unsigned DIV_SIDE_W  = 1;

  typedef logic signed [31:0] q_t;
  typedef logic signed [65:0] prod_t;

  localparam q_t                  Q_MAX     = 32'sh7FFF_FFFF;
  localparam q_t                  Q_MIN     = 32'sh8000_0000;
  localparam logic [FACTOR_W-1:0] ONE_Q     = 20'd65536;
  localparam logic [WIDE_W-1:0]   RECIP_NUM = 64'h0000_0001_0000_0000;
  localparam logic [NUM_W-1:0]    LIM_NEG   = 48'h0000_8000_0000;
  localparam logic [NUM_W-1:0]    LIM_POS   = 48'h0000_7FFF_FFFF;

  typedef struct packed {
    logic [63:0]        arm_one;
    logic [63:0]        arm_two;
    logic [63:0]        velocity_one;
    logic [63:0]        velocity_two;
    logic [63:0]        contact_normal;
    logic signed [31:0] spin_one;
    logic signed [31:0] spin_two;
    logic [63:0]        mass_inertia_one;
    logic [63:0]        mass_inertia_two;
    logic [31:0]        restitution_pair;
  } item_t;

  typedef struct packed {
    logic [63:0]        new_velocity_one;
    logic signed [31:0] new_spin_one;
    logic [63:0]        new_velocity_two;
    logic signed [31:0] new_spin_two;
    logic signed [31:0] impulse_value;
    logic               divide_fault;
  } result_t;

  // Per-contact context carried down the pipeline.
  typedef struct packed {
    q_t          v1x;
    q_t          v1y;
    q_t          v2x;
    q_t          v2y;
    q_t          w1;
    q_t          w2;
    q_t          nx;
    q_t          ny;
    q_t          nr1;
    q_t          nr2;
    logic [31:0] m1;
    logic [31:0] m2;
    logic [31:0] i1;
    logic [31:0] i2;
    logic        fault;
  } ctx_t;

  function automatic logic signed [32:0] ext33(input q_t a);
    return {a[31], a};
  endfunction

  function automatic prod_t mul33(input logic signed [32:0] a,
                                  input logic signed [32:0] b);
    return a * b;
  endfunction

  function automatic q_t sat34(input logic signed [33:0] x);
    q_t r;
    if (x[33:31] == 3'b000 || x[33:31] == 3'b111) begin
      r = x[31:0];
    end else begin
      r = x[33] ? Q_MIN : Q_MAX;
    end
    return r;
  endfunction

  function automatic q_t add_sat(input q_t a, input q_t b);
    return sat34({{2{a[31]}}, a} + {{2{b[31]}}, b});
  endfunction

  function automatic q_t sub_sat(input q_t a, input q_t b);
    return sat34({{2{a[31]}}, a} - {{2{b[31]}}, b});
  endfunction

  // Floor of product / 2^16, saturated to 32 bits.
  function automatic q_t qfloor(input prod_t p);
    q_t r;
    if (p[65:47] == '0 || p[65:47] == '1) begin
      r = p[47:16];
    end else begin
      r = p[65] ? Q_MIN : Q_MAX;
    end
    return r;
  endfunction

  function automatic q_t neg_sat(input q_t a);
    return (a == Q_MIN) ? Q_MAX : -a;
  endfunction

  // Apply sign to an unsigned quotient and saturate.
  function automatic q_t qdiv_sat(input logic [NUM_W-1:0] q, input logic neg);
    q_t r;
    if (neg) begin
      r = (q >= LIM_NEG) ? Q_MIN : -q_t'(q[31:0]);
    end else begin
      r = (q > LIM_POS) ? Q_MAX : q_t'(q[31:0]);
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/rbir_div_pipe.sv -----
// ----------------------------------------------------------------------------
// rbir_div_pipe
// Pipelined restoring divider, one quotient bit per stage, several lanes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rbir_div_pipe
  import rbir_pkg::*;
#(
  parameter int unsigned LANES = DIV_LANES,
  parameter int unsigned NW    = DIV_NUM_W,
  parameter int unsigned DW    = DIV_DEN_W,
  parameter int unsigned SW    = DIV_SIDE_W
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [LANES-1:0][NW-1:0]   num,
  input  logic [LANES-1:0][DW-1:0]   den,
  input  logic [SW-1:0]              side_in,
  output logic                       out_valid,
  output logic [LANES-1:0][NW-1:0]   quo,
  output logic [SW-1:0]              side_out
);

  logic                     vld [NW];
  logic [LANES-1:0][NW-1:0] nq  [NW];
  logic [LANES-1:0][DW-1:0] rem [NW];
  logic [LANES-1:0][DW-1:0] dv  [NW];
  logic [SW-1:0]            sd  [NW];

  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic                     p_vld;
    logic [LANES-1:0][NW-1:0] p_nq;
    logic [LANES-1:0][DW-1:0] p_rem;
    logic [LANES-1:0][DW-1:0] p_dv;
    logic [SW-1:0]            p_sd;
    logic [LANES-1:0][NW-1:0] nq_next;
    logic [LANES-1:0][DW-1:0] rem_next;

    if (s == 0) begin : g_first
      assign p_vld = in_valid;
      assign p_nq  = num;
      assign p_rem = '0;
      assign p_dv  = den;
      assign p_sd  = side_in;
    end else begin : g_rest
      assign p_vld = vld[s-1];
      assign p_nq  = nq[s-1];
      assign p_rem = rem[s-1];
      assign p_dv  = dv[s-1];
      assign p_sd  = sd[s-1];
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [DW:0] trial;
      logic [DW:0] diff;
      logic        ge;
      assign trial       = {p_rem[l], p_nq[l][NW-1]};
      assign diff        = trial - {1'b0, p_dv[l]};
      assign ge          = (trial >= {1'b0, p_dv[l]});
      assign rem_next[l] = ge ? diff[DW-1:0] : trial[DW-1:0];
      // Shift out a numerator bit, shift in a quotient bit.
      assign nq_next[l]  = {p_nq[l][NW-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= p_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nq[s]  <= nq_next;
        rem[s] <= rem_next;
        dv[s]  <= p_dv;
        sd[s]  <= p_sd;
      end
    end
  end

  assign out_valid = vld[NW-1];
  assign quo       = nq[NW-1];
  assign side_out  = sd[NW-1];

endmodule

// ----- hw/rtl/rigid_body_impulse_resolver_unit.sv -----
// ----------------------------------------------------------------------------
// rigid_body_impulse_resolver_unit
// Resolves one 2D two-body contact per transfer by a normal impulse.
// ----------------------------------------------------------------------------
//  channel | signals                           | payload
//  --------+-----------------------------------+----------------------------
//  input   | item_valid / item_stall / item     | item_t, one contact
//  output  | result_valid / result_stall / result | result_t, one per contact
//
//  Accepts one contact every cycle while the output is not stalled. The pipe
//  is made of three bit-serial divider pipelines (64 + 48 + 48 stages) plus 17
//  stages of multiply, round, saturate and add around them.
//  Reset (rst, synchronous) clears only the stage valid bits.
//  A stall on the output freezes every stage at once; nothing is dropped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rigid_body_impulse_resolver_unit_defines.svh"

module rigid_body_impulse_resolver_unit
  import rbir_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  typedef struct packed {
    ctx_t ctx;
    q_t   numer;
  } a_side_t;

  typedef struct packed {
    ctx_t ctx;
    logic neg;
  } b_side_t;

  typedef struct packed {
    ctx_t ctx;
    q_t   imp;
  } c_side_t;

  // Whole pipeline advances unless a finished result is held off.
  logic en;
  assign en         = !(result_valid && result_stall);
  assign item_stall = !en;

  // --------------------------------------------------------------------------
  // Front end: decode, point velocities, relative velocity, numerator
  // --------------------------------------------------------------------------
  logic [10:1]         pre_vld;
  item_t               s1_item;

  ctx_t                dec_ctx;
  prod_t [7:0]         dec_p;
  logic [31:0]         e_prod;

  ctx_t                s2_ctx, s3_ctx, s4_ctx, s5_ctx, s6_ctx, s7_ctx;
  ctx_t                s8_ctx, s9_ctx, s10_ctx;
  ctx_t                s4_ctx_next;
  prod_t [7:0]         s2_p;
  logic [17:0]         s2_eh;
  q_t [7:0]            s3_q;
  logic [FACTOR_W-1:0] s3_factor, s4_factor, s5_factor, s6_factor, s7_factor;
  logic [FACTOR_W-1:0] s8_factor;
  q_t [3:0]            s4_pv;
  q_t                  s5_dx, s5_dy;
  logic [WIDE_W-1:0]   s5_sq1, s5_sq2, s6_sq1, s6_sq2, s7_sq1, s7_sq2;
  logic [WIDE_W-1:0]   s8_sq1, s8_sq2, s9_sq1, s9_sq2, s10_sq1, s10_sq2;
  prod_t               s6_pdx, s6_pdy;
  q_t                  s7_qdx, s7_qdy;
  q_t                  s8_rel;
  prod_t               s9_pfr;
  q_t                  s10_numer;
  logic signed [63:0]  sq1_full, sq2_full;

  always_comb begin
    dec_ctx.v1x   = s1_item.velocity_one[63:32];
    dec_ctx.v1y   = s1_item.velocity_one[31:0];
    dec_ctx.v2x   = s1_item.velocity_two[63:32];
    dec_ctx.v2y   = s1_item.velocity_two[31:0];
    dec_ctx.w1    = s1_item.spin_one;
    dec_ctx.w2    = s1_item.spin_two;
    dec_ctx.nx    = s1_item.contact_normal[63:32];
    dec_ctx.ny    = s1_item.contact_normal[31:0];
    dec_ctx.nr1   = '0;
    dec_ctx.nr2   = '0;
    dec_ctx.m1    = s1_item.mass_inertia_one[63:32];
    dec_ctx.i1    = s1_item.mass_inertia_one[31:0];
    dec_ctx.m2    = s1_item.mass_inertia_two[63:32];
    dec_ctx.i2    = s1_item.mass_inertia_two[31:0];
    dec_ctx.fault = (dec_ctx.m1 == '0) || (dec_ctx.m2 == '0) ||
                    (dec_ctx.i1 == '0) || (dec_ctx.i2 == '0);
    // spin * perp(arm), then perp(arm) . n
    dec_p[0] = mul33(-ext33(q_t'(s1_item.arm_one[31:0])), ext33(dec_ctx.w1));
    dec_p[1] = mul33(ext33(q_t'(s1_item.arm_one[63:32])), ext33(dec_ctx.w1));
    dec_p[2] = mul33(-ext33(q_t'(s1_item.arm_two[31:0])), ext33(dec_ctx.w2));
    dec_p[3] = mul33(ext33(q_t'(s1_item.arm_two[63:32])), ext33(dec_ctx.w2));
    dec_p[4] = mul33(-ext33(q_t'(s1_item.arm_one[31:0])), ext33(dec_ctx.nx));
    dec_p[5] = mul33(ext33(q_t'(s1_item.arm_one[63:32])), ext33(dec_ctx.ny));
    dec_p[6] = mul33(-ext33(q_t'(s1_item.arm_two[31:0])), ext33(dec_ctx.nx));
    dec_p[7] = mul33(ext33(q_t'(s1_item.arm_two[63:32])), ext33(dec_ctx.ny));
    e_prod   = 32'(s1_item.restitution_pair[31:16]) *
               32'(s1_item.restitution_pair[15:0]);
  end

  // Normal lever terms join the context before it moves on.
  always_comb begin
    s4_ctx_next     = s3_ctx;
    s4_ctx_next.nr1 = add_sat(s3_q[4], s3_q[5]);
    s4_ctx_next.nr2 = add_sat(s3_q[6], s3_q[7]);
  end

  assign sq1_full = s4_ctx.nr1 * s4_ctx.nr1;
  assign sq2_full = s4_ctx.nr2 * s4_ctx.nr2;

  always_ff @(posedge clk) begin
    if (rst) begin
      pre_vld <= '0;
    end else if (en) begin
      pre_vld <= {pre_vld[9:1], item_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_item <= item;
      // products
      s2_ctx <= dec_ctx;
      s2_p   <= dec_p;
      s2_eh  <= e_prod[31:14];
      // round and saturate, restitution factor
      s3_ctx <= s2_ctx;
      for (int k = 0; k < 8; k++) begin
        s3_q[k] <= qfloor(s2_p[k]);
      end
      s3_factor <= ONE_Q + {2'b00, s2_eh};
      // point velocities and normal lever terms
      s4_ctx     <= s4_ctx_next;
      s4_pv[0]   <= add_sat(s3_ctx.v1x, s3_q[0]);
      s4_pv[1]   <= add_sat(s3_ctx.v1y, s3_q[1]);
      s4_pv[2]   <= add_sat(s3_ctx.v2x, s3_q[2]);
      s4_pv[3]   <= add_sat(s3_ctx.v2y, s3_q[3]);
      s4_factor  <= s3_factor;
      // velocity difference, squared lever terms
      s5_ctx    <= s4_ctx;
      s5_dx     <= sub_sat(s4_pv[0], s4_pv[2]);
      s5_dy     <= sub_sat(s4_pv[1], s4_pv[3]);
      s5_sq1    <= sq1_full;
      s5_sq2    <= sq2_full;
      s5_factor <= s4_factor;
      // normal projection
      s6_ctx    <= s5_ctx;
      s6_pdx    <= mul33(ext33(s5_ctx.nx), ext33(s5_dx));
      s6_pdy    <= mul33(ext33(s5_ctx.ny), ext33(s5_dy));
      s6_sq1    <= s5_sq1;
      s6_sq2    <= s5_sq2;
      s6_factor <= s5_factor;
      s7_ctx    <= s6_ctx;
      s7_qdx    <= qfloor(s6_pdx);
      s7_qdy    <= qfloor(s6_pdy);
      s7_sq1    <= s6_sq1;
      s7_sq2    <= s6_sq2;
      s7_factor <= s6_factor;
      s8_ctx    <= s7_ctx;
      s8_rel    <= add_sat(s7_qdx, s7_qdy);
      s8_sq1    <= s7_sq1;
      s8_sq2    <= s7_sq2;
      s8_factor <= s7_factor;
      // numerator = -(1 + e1*e2) * rel
      s9_ctx    <= s8_ctx;
      s9_pfr    <= mul33({13'b0, s8_factor}, ext33(s8_rel));
      s9_sq1    <= s8_sq1;
      s9_sq2    <= s8_sq2;
      s10_ctx   <= s9_ctx;
      s10_numer <= neg_sat(qfloor(s9_pfr));
      s10_sq1   <= s9_sq1;
      s10_sq2   <= s9_sq2;
    end
  end

  // --------------------------------------------------------------------------
  // Denominator terms: 2^32/m1, 2^32/m2, nr1^2/I1, nr2^2/I2
  // --------------------------------------------------------------------------
  logic [3:0][WIDE_W-1:0] da_num;
  logic [3:0][WORD_W-1:0] da_den;
  logic [3:0][WIDE_W-1:0] da_quo;
  a_side_t                da_side_in, da_side;
  logic                   da_vld;

  always_comb begin
    da_num[0]           = RECIP_NUM;
    da_num[1]           = RECIP_NUM;
    da_num[2]           = s10_sq1;
    da_num[3]           = s10_sq2;
    da_den[0]           = s10_ctx.m1;
    da_den[1]           = s10_ctx.m2;
    da_den[2]           = s10_ctx.i1;
    da_den[3]           = s10_ctx.i2;
    da_side_in.ctx      = s10_ctx;
    da_side_in.numer    = s10_numer;
  end

  rbir_div_pipe #(
    .LANES (4),
    .NW    (WIDE_W),
    .DW    (WORD_W),
    .SW    ($bits(a_side_t))
  ) u_div_den (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (pre_vld[10]),
    .num       (da_num),
    .den       (da_den),
    .side_in   (da_side_in),
    .out_valid (da_vld),
    .quo       (da_quo),
    .side_out  (da_side)
  );

  // --------------------------------------------------------------------------
  // Sum the denominator, then j = numer * 2^16 / D
  // --------------------------------------------------------------------------
  logic              d1_vld, d2_vld;
  a_side_t           d1_side;
  logic [WIDE_W-1:0] d1_sum_m, d1_sum_i;
  logic [WORD_W-1:0] d1_mag;
  logic signed [32:0] numer_abs;
  b_side_t           d2_side;
  b_side_t           d2_side_next;
  logic [WIDE_W-1:0] d2_den;
  logic [NUM_W-1:0]  d2_num;

  assign numer_abs = da_side.numer[31] ? -ext33(da_side.numer) : ext33(da_side.numer);

  always_comb begin
    d2_side_next.ctx       = d1_side.ctx;
    // sums never wrap, so D is zero only when both halves are
    d2_side_next.ctx.fault = d1_side.ctx.fault ||
                             (d1_sum_m == '0 && d1_sum_i == '0);
    d2_side_next.neg       = d1_side.numer[31];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1_side  <= da_side;
      d1_sum_m <= da_quo[0] + da_quo[1];
      d1_sum_i <= da_quo[2] + da_quo[3];
      d1_mag   <= numer_abs[31:0];
      d2_side  <= d2_side_next;
      d2_den   <= d1_sum_m + d1_sum_i;
      d2_num   <= {d1_mag, 16'b0};
    end
  end

  logic             db_vld;
  logic [NUM_W-1:0] db_quo;
  b_side_t          db_side;

  rbir_div_pipe #(
    .LANES (1),
    .NW    (NUM_W),
    .DW    (WIDE_W),
    .SW    ($bits(b_side_t))
  ) u_div_imp (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (d2_vld),
    .num       (d2_num),
    .den       (d2_den),
    .side_in   (d2_side),
    .out_valid (db_vld),
    .quo       (db_quo),
    .side_out  (db_side)
  );

  // --------------------------------------------------------------------------
  // Saturate j, then j/m1, j/m2, j/I1, j/I2
  // --------------------------------------------------------------------------
  logic              e1_vld;
  ctx_t              e1_ctx;
  q_t                e1_imp;
  logic [WORD_W-1:0] e1_mag;
  logic [NUM_W-1:0]  mag_sat;

  always_comb begin
    if (db_side.neg) begin
      mag_sat = (db_quo >= LIM_NEG) ? LIM_NEG : db_quo;
    end else begin
      mag_sat = (db_quo > LIM_POS) ? LIM_POS : db_quo;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e1_ctx <= db_side.ctx;
      e1_imp <= qdiv_sat(db_quo, db_side.neg);
      e1_mag <= mag_sat[31:0];
    end
  end

  logic [3:0][NUM_W-1:0]  dc_num;
  logic [3:0][WORD_W-1:0] dc_den;
  logic [3:0][NUM_W-1:0]  dc_quo;
  c_side_t                dc_side_in, dc_side;
  logic                   dc_vld;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      dc_num[k] = {e1_mag, 16'b0};
    end
    dc_den[0]      = e1_ctx.m1;
    dc_den[1]      = e1_ctx.m2;
    dc_den[2]      = e1_ctx.i1;
    dc_den[3]      = e1_ctx.i2;
    dc_side_in.ctx = e1_ctx;
    dc_side_in.imp = e1_imp;
  end

  rbir_div_pipe #(
    .LANES (4),
    .NW    (NUM_W),
    .DW    (WORD_W),
    .SW    ($bits(c_side_t))
  ) u_div_share (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (e1_vld),
    .num       (dc_num),
    .den       (dc_den),
    .side_in   (dc_side_in),
    .out_valid (dc_vld),
    .quo       (dc_quo),
    .side_out  (dc_side)
  );

  // --------------------------------------------------------------------------
  // Back end: scale by normal / lever term, apply, pick fault pass-through
  // --------------------------------------------------------------------------
  logic        f1_vld, f2_vld, f3_vld;
  ctx_t        f1_ctx, f2_ctx, f3_ctx;
  q_t          f1_imp, f2_imp, f3_imp;
  q_t [3:0]    f1_sc;
  prod_t [5:0] f2_p;
  q_t [5:0]    f3_q;
  result_t     res_next;

  always_ff @(posedge clk) begin
    if (en) begin
      f1_ctx <= dc_side.ctx;
      f1_imp <= dc_side.imp;
      for (int k = 0; k < 4; k++) begin
        f1_sc[k] <= qdiv_sat(dc_quo[k], dc_side.imp[31]);
      end
      f2_ctx  <= f1_ctx;
      f2_imp  <= f1_imp;
      f2_p[0] <= mul33(ext33(f1_ctx.nx), ext33(f1_sc[0]));
      f2_p[1] <= mul33(ext33(f1_ctx.ny), ext33(f1_sc[0]));
      f2_p[2] <= mul33(ext33(f1_ctx.nr1), ext33(f1_sc[2]));
      f2_p[3] <= mul33(ext33(f1_ctx.nx), ext33(f1_sc[1]));
      f2_p[4] <= mul33(ext33(f1_ctx.ny), ext33(f1_sc[1]));
      f2_p[5] <= mul33(ext33(f1_ctx.nr2), ext33(f1_sc[3]));
      f3_ctx  <= f2_ctx;
      f3_imp  <= f2_imp;
      for (int k = 0; k < 6; k++) begin
        f3_q[k] <= qfloor(f2_p[k]);
      end
      result <= res_next;
    end
  end

  always_comb begin
    if (f3_ctx.fault) begin
      res_next.new_velocity_one = {f3_ctx.v1x, f3_ctx.v1y};
      res_next.new_spin_one     = f3_ctx.w1;
      res_next.new_velocity_two = {f3_ctx.v2x, f3_ctx.v2y};
      res_next.new_spin_two     = f3_ctx.w2;
      res_next.impulse_value    = '0;
      res_next.divide_fault     = 1'b1;
    end else begin
      res_next.new_velocity_one = {add_sat(f3_ctx.v1x, f3_q[0]),
                                   add_sat(f3_ctx.v1y, f3_q[1])};
      res_next.new_spin_one     = add_sat(f3_ctx.w1, f3_q[2]);
      res_next.new_velocity_two = {sub_sat(f3_ctx.v2x, f3_q[3]),
                                   sub_sat(f3_ctx.v2y, f3_q[4])};
      res_next.new_spin_two     = sub_sat(f3_ctx.w2, f3_q[5]);
      res_next.impulse_value    = f3_imp;
      res_next.divide_fault     = 1'b0;
    end
  end

  // Valid bits for the stages outside the dividers.
  always_ff @(posedge clk) begin
    if (rst) begin
      d1_vld       <= 1'b0;
      d2_vld       <= 1'b0;
      e1_vld       <= 1'b0;
      f1_vld       <= 1'b0;
      f2_vld       <= 1'b0;
      f3_vld       <= 1'b0;
      result_valid <= 1'b0;
    end else if (en) begin
      d1_vld       <= da_vld;
      d2_vld       <= d1_vld;
      e1_vld       <= db_vld;
      f1_vld       <= dc_vld;
      f2_vld       <= f1_vld;
      f3_vld       <= f2_vld;
      result_valid <= f3_vld;
    end
  end

  // An accepted transfer enters the first stage.
  `RBIR_ASSERT_NXT(a_accept_enters, clk, rst, item_valid && !item_stall, pre_vld[1])
  // A fault never reports an impulse.
  `RBIR_ASSERT_IMP(a_fault_no_impulse, clk, rst, result_valid && result.divide_fault, result.impulse_value == '0)
  // Nonzero masses give a nonzero inverse-mass sum.
  `RBIR_ASSERT_IMP(a_inv_mass_nonzero, clk, rst, d1_vld && d1_side.ctx.m1 != '0 && d1_side.ctx.m2 != '0, d1_sum_m != '0)

endmodule
